### rtl/wwc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the whole-word censor filter.
// No dependencies; imported by every module of the block.
package wwc_pkg;

  localparam int MAX_WORD_DEFAULT = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W = 5;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic commit;
    logic mask;
    logic last;
  } cell_t;

  typedef struct packed {
    logic step;
    logic load;
    logic commit;
    logic mask;
    logic last;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0] ch;
    logic last;
  } out_item_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == 8'h2C || c == 8'h3B || c == 8'h3A || c == 8'h2E || c == 8'h22 ||
           c == 8'h21 || c == 8'h3F || c == 8'h0A || c == 8'h27 || c == 8'h20;
  endfunction

endpackage

### rtl/whole_word_censor_filter_core.sv
`timescale 1ns / 1ps
// Top level of the whole-word censor filter: configuration, match control, cell chain.
// Depends on wwc_pkg, wwc_cell and wwc_obuf.
//
//   Channel   Dir  Fields (tdata low bit up / tuser / tlast)
//   s_axis    in   tdata: text_byte[7:0]; tlast: is_final
//   m_axis    out  tdata: out_byte[7:0]; tlast: out_final
//   cfg       in   index 0 word_bytes_low, 1 word_bytes_high, 2 word_length
//
// One text byte is taken per cycle while each transaction commits at most one result byte
// and the output buffer has room. Every result byte leaves the front cell of the chain,
// one per cycle, through a two-entry output buffer; a byte taken now leaves after
// word-length later bytes. An input that commits n bytes holds the input until all n have
// left (two when the window drains after a length change, the word length on a match, up
// to MAX_WORD + 1 on the final byte). Reset is synchronous and empties the chain.
module whole_word_censor_filter_core #(
  parameter int MAX_WORD = wwc_pkg::MAX_WORD_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // text_byte[7:0]
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // out_byte[7:0]
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [wwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wwc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wwc_pkg::*;

  localparam int NC = MAX_WORD + 1;
  localparam int CW = $clog2(MAX_WORD + 1);

  logic [CFG_DATA_W-1:0] word_low;
  logic [CFG_DATA_W-1:0] word_high;
  logic [LEN_W-1:0]      word_length;
  logic [2*CFG_DATA_W-1:0] word_all;
  logic [7:0]            wch [MAX_WORD];

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          pb;
  logic          pb_next;

  cell_t     cur [NC];
  cell_t     view [NC];
  cell_t     nxt [NC];
  cell_ctl_t ctl [NC];

  logic [CW-1:0]       eff_len;
  logic [CW-1:0]       len_m1;
  logic [MAX_WORD-1:0] len_mask;
  logic [MAX_WORD-1:0] lenm1_mask;
  logic [MAX_WORD-1:0] eq0;
  logic [MAX_WORD-1:0] eq1;
  logic [MAX_WORD-1:0] eq2;
  logic [7:0]          w_last;
  logic                sep_lm1;

  logic [7:0]    c_fold;
  logic          c_sep;
  logic          accept;
  logic          is_last;
  logic          shift;
  logic          ob_room;
  logic          win_gt;
  logic          win_eq;
  logic          main_hit;
  logic          mask_run;
  logic          pop_one;
  logic          pb_step;
  logic [CW-1:0] fill_step;
  logic          tail_hit;
  logic          end_hit;
  out_item_t     ob_in;
  out_item_t     ob_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_low    <= '0;
      word_high   <= '0;
      word_length <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORD_LOW:    word_low <= cfg_data;
        CFG_WORD_HIGH:   word_high <= cfg_data;
        CFG_WORD_LENGTH: word_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign word_all = {word_high, word_low};

  always_comb begin
    for (int i = 0; i < MAX_WORD; i++) begin
      wch[i] = fold(word_all[8*i +: 8]);
    end
  end

  always_comb begin
    if (word_length == '0) begin
      eff_len = CW'(1);
    end else if (word_length > LEN_W'(MAX_WORD)) begin
      eff_len = CW'(MAX_WORD);
    end else begin
      eff_len = CW'(word_length);
    end
  end

  assign len_m1 = CW'(eff_len - 1'b1);

  always_comb begin
    for (int i = 0; i < MAX_WORD; i++) begin
      len_mask[i]   = CW'(i) < eff_len;
      lenm1_mask[i] = CW'(i) < len_m1;
    end
  end

  // Cell chain; the top cell refills with an empty cell on a shift.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    if (i == NC - 1) begin : g_end
      assign nxt[i] = cell_t'('0);
    end else begin : g_mid
      assign nxt[i] = cur[i+1];
    end
    wwc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .nxt   (nxt[i]),
      .ctl   (ctl[i]),
      .din   (c_fold),
      .cur   (cur[i]),
      .view  (view[i])
    );
  end

  // Window compares at offsets of zero, one and two cells.
  for (genvar i = 0; i < MAX_WORD; i++) begin : g_eq
    assign eq0[i] = view[i].ch == wch[i];
    assign eq1[i] = view[i+1].ch == wch[i];
    if (i + 2 < NC) begin : g_two
      assign eq2[i] = view[i+2].ch == wch[i];
    end else begin : g_none
      assign eq2[i] = 1'b0;
    end
  end

  always_comb begin
    w_last  = wch[0];
    sep_lm1 = is_sep(view[0].ch);
    for (int i = 0; i < MAX_WORD; i++) begin
      if (CW'(i) == len_m1) begin
        w_last  = wch[i];
        sep_lm1 = is_sep(view[i].ch);
      end
    end
  end

  assign shift = cur[0].commit && ob_room;
  assign s_axis_tready = !view[0].commit;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign is_last = s_axis_tlast;
  assign c_fold = fold(s_axis_tdata);
  assign c_sep = is_sep(c_fold);

  assign win_gt   = fill > eff_len;
  assign win_eq   = fill == eff_len;
  assign main_hit = win_eq && pb && (&(eq0 | ~len_mask));
  assign mask_run = main_hit && c_sep;
  assign pop_one  = win_eq && !mask_run;

  always_comb begin
    if (win_gt) begin
      pb_step   = is_sep(view[1].ch);
      fill_step = CW'(fill - 1'b1);
      tail_hit  = &(eq2 | ~lenm1_mask);
    end else if (mask_run) begin
      pb_step   = sep_lm1;
      fill_step = CW'(1);
      tail_hit  = 1'b1;
    end else if (pop_one) begin
      pb_step   = is_sep(view[0].ch);
      fill_step = fill;
      tail_hit  = &(eq1 | ~lenm1_mask);
    end else begin
      pb_step   = pb;
      fill_step = CW'(fill + 1'b1);
      tail_hit  = &(eq0 | ~lenm1_mask);
    end
  end

  assign end_hit = (fill_step == eff_len) && pb_step && (c_fold == w_last) && tail_hit;

  always_comb begin
    logic pre;
    logic upto;
    for (int i = 0; i < NC; i++) begin
      pre  = (win_gt && i < 2) || (mask_run && CW'(i) < eff_len) || (pop_one && i == 0);
      upto = CW'(i) <= fill;
      ctl[i].step   = accept;
      ctl[i].load   = accept && (CW'(i) == fill);
      ctl[i].commit = pre || (is_last && upto);
      ctl[i].mask   = (mask_run && CW'(i) < eff_len) || (is_last && end_hit && !pre && upto);
      ctl[i].last   = is_last && (CW'(i) == fill);
    end
  end

  always_comb begin
    fill_next = fill;
    pb_next   = pb;
    if (accept) begin
      if (is_last) begin
        fill_next = '0;
        pb_next   = 1'b1;
      end else begin
        fill_next = fill_step;
        pb_next   = pb_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pb   <= 1'b1;
    end else begin
      fill <= fill_next;
      pb   <= pb_next;
    end
  end

  assign ob_in = '{ch: cur[0].mask ? MASK_CHAR : cur[0].ch, last: cur[0].last};

  wwc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (shift),
    .push_item (ob_in),
    .room      (ob_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (ob_out)
  );

  assign m_axis_tdata = ob_out.ch;
  assign m_axis_tlast = ob_out.last;

endmodule

### rtl/wwc_cell.sv
`timescale 1ns / 1ps
// One window cell: holds a character and its emit flags, shifts toward the output.
// Depends on wwc_pkg.
module wwc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  wwc_pkg::cell_t    nxt,
  input  wwc_pkg::cell_ctl_t ctl,
  input  logic [7:0]        din,
  output wwc_pkg::cell_t    cur,
  output wwc_pkg::cell_t    view
);
  import wwc_pkg::*;

  logic [7:0] ch;
  logic       committed;
  logic       masked;
  logic       last_flag;

  assign cur = '{ch: ch, commit: committed, mask: masked, last: last_flag};

  always_comb begin
    view = shift ? nxt : cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= 1'b0;
    end else begin
      committed <= ctl.step ? ctl.commit : view.commit;
    end
  end

  always_ff @(posedge clk) begin
    ch        <= ctl.load ? din : view.ch;
    masked    <= ctl.step ? ctl.mask : view.mask;
    last_flag <= ctl.step ? ctl.last : view.last;
  end

endmodule

### rtl/wwc_obuf.sv
`timescale 1ns / 1ps
// Two-entry output buffer that decouples the cell chain from the output stream.
// Depends on wwc_pkg.
module wwc_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wwc_pkg::out_item_t  push_item,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output wwc_pkg::out_item_t  out_item
);
  import wwc_pkg::*;

  out_item_t head;
  out_item_t tail;
  logic      head_valid;
  logic      tail_valid;
  logic      pop;

  assign pop = head_valid && out_ready;
  assign room = !tail_valid;
  assign out_valid = head_valid;
  assign out_item = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop && tail_valid) begin
      tail_valid <= 1'b0;
    end else if (pop) begin
      head_valid <= push;
    end else if (push) begin
      if (head_valid) begin
        tail_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tail_valid) begin
      head <= tail;
    end else if (push && (pop || !head_valid)) begin
      head <= push_item;
    end
    if (push && head_valid && !pop) begin
      tail <= push_item;
    end
  end

endmodule

### sim/whole_word_censor_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for whole_word_censor_filter_core: directed plan, then random texts.
// Depends on wwc_pkg and the core RTL; an internal predictor supplies all but typed results.
module whole_word_censor_filter_core_tb;
  import wwc_pkg::*;

  localparam int WORD_MAX = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int TEXT_TARGET = 410;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] BREAKS [10] = '{",", ";", ":", ".", "\"", "!", "?", 8'h0A, "'", " "};

  typedef enum logic {ROW_TEXT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0] ch;
    logic fin;
    logic typed;
    logic [7:0] want;
  } plan_row_t;

  localparam int PLAN_ROWS = 34;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "A", 1'b1, 1'b1, "a"},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, 8'h00, 1'b1, 1'b1, MASK_CHAR},
    '{ROW_REG, CFG_WORD_LOW, 64'h0000_0000_0074_6143, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "c", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "A", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "T", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, " ", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "c", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "a", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "t", 1'b1, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "C", 1'b1, 1'b1, MASK_CHAR},
    '{ROW_REG, CFG_WORD_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_HIGH, 64'h8080_8080_8080_8080, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, 8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "Z", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "@", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "[", 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, ".", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "Q", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "?", 1'b1, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LOW, 64'h0000_0000_0061_2061, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_WORD_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_REG, CFG_UNUSED, 64'h5A5A_5A5A_5A5A_5A5A, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "a", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, " ", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "a", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, " ", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "a", 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, CFG_WORD_LOW, 64'd0, "!", 1'b1, 1'b0, 8'h00}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WORD_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state.
  logic [7:0] win [WORD_MAX];
  int fill;
  bit after_break;
  logic [63:0] word_lo;
  logic [63:0] word_hi;
  logic [4:0] len_reg;
  logic [7:0] step_bytes [$];
  out_item_t censored_q [$];

  bit calm;
  int text_sent;
  int texts_done;
  int cfg_phases;
  int results_checked;
  int masked_bytes;
  int mismatches;
  out_item_t seen_want;

  whole_word_censor_filter_core u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic bit is_break(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (c == BREAKS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > WORD_MAX) return WORD_MAX;
    return int'(len_reg);
  endfunction

  function automatic logic [7:0] word_char(input int i);
    return lower_case(i < 8 ? word_lo[8*i +: 8] : word_hi[8*(i-8) +: 8]);
  endfunction

  function automatic bit word_in_window(input int l);
    bit ok;
    ok = (fill == l) && after_break;
    for (int i = 0; i < l; i++) begin
      if (win[i] != word_char(i)) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic release_oldest();
    step_bytes.push_back(win[0]);
    after_break = is_break(win[0]);
    for (int i = 0; i < WORD_MAX - 1; i++) win[i] = win[i+1];
    fill--;
  endtask

  task automatic emit_masked(input int l);
    for (int i = 0; i < l; i++) step_bytes.push_back(MASK_CHAR);
    masked_bytes += l;
  endtask

  // Works out the bytes that leave when one text byte is taken.
  task automatic censor_step(input logic [7:0] raw, input bit fin);
    logic [7:0] c;
    int l;
    c = lower_case(raw);
    l = active_len();
    step_bytes.delete();
    if (fill > l) begin
      release_oldest();
      release_oldest();
    end else if (fill == l) begin
      if (word_in_window(l) && is_break(c)) begin
        emit_masked(l);
        after_break = is_break(win[l-1]);
        fill = 0;
      end else begin
        release_oldest();
      end
    end
    if (fill < WORD_MAX) begin
      win[fill] = c;
      fill++;
    end
    if (fin) begin
      if (word_in_window(l)) begin
        emit_masked(l);
      end else begin
        for (int i = 0; i < fill; i++) step_bytes.push_back(win[i]);
      end
      fill = 0;
      after_break = 1'b1;
    end
  endtask

  task automatic push_text(input logic [7:0] ch, input bit fin, input bit typed,
                           input logic [7:0] typed_ch);
    int gap;
    out_item_t item;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 20) begin
      gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(2, 4)) : 1;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    censor_step(ch, fin);
    if (typed) begin
      step_bytes.delete();
      step_bytes.push_back(typed_ch);
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      item.ch = step_bytes[i];
      item.last = fin && (i == step_bytes.size() - 1);
      censored_q.push_back(item);
    end
    text_sent++;
    if (fin) texts_done++;
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (censored_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WORD_LOW: word_lo = val;
      CFG_WORD_HIGH: word_hi = val;
      CFG_WORD_LENGTH: len_reg = val[4:0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (censored_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: byte %h last %b", m_axis_tdata, m_axis_tlast);
        end
      end else begin
        seen_want = censored_q.pop_front();
        if (m_axis_tdata !== seen_want.ch || m_axis_tlast !== seen_want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     seen_want.ch, seen_want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] text_q [$];
    logic [7:0] ch;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    int eff;
    int r;
    int n;
    for (int i = 0; i < WORD_MAX; i++) win[i] = 8'h00;
    fill = 0;
    after_break = 1'b1;
    word_lo = '0;
    word_hi = '0;
    len_reg = 5'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].kind == ROW_REG) begin
        drain_outputs();
        write_reg(PLAN[row].idx, PLAN[row].data);
      end else begin
        push_text(PLAN[row].ch, PLAN[row].fin, PLAN[row].typed, PLAN[row].want);
      end
    end

    while (text_sent < TEXT_TARGET) begin
      calm = (text_sent >= 200 && text_sent < 300);
      lo = '0;
      hi = '0;
      for (int k = 0; k < WORD_MAX; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          ch = BREAKS[$urandom_range(0, 9)];
        end else if (r < 15) begin
          ch = 8'($urandom_range(0, 255));
        end else begin
          ch = 8'(8'h61 + $urandom_range(0, 25));
          if ($urandom_range(0, 1)) ch = ch ^ 8'h20;
        end
        if (k < 8) lo[8*k +: 8] = ch;
        else hi[8*(k-8) +: 8] = ch;
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = 5'($urandom_range(1, 6));
      else if (r < 85) len = 5'($urandom_range(7, 16));
      else if (r < 93) len = 5'd0;
      else len = 5'($urandom_range(17, 31));
      drain_outputs();
      write_reg(CFG_WORD_LOW, lo);
      write_reg(CFG_WORD_HIGH, hi);
      write_reg(CFG_WORD_LENGTH, {59'd0, len});
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
      cfg_phases++;
      eff = active_len();

      text_q.delete();
      n = $urandom_range(1, 10);
      for (int t = 0; t < n; t++) begin
        if (t > 0 || $urandom_range(0, 1)) begin
          r = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 2));
          for (int s = 0; s < r; s++) text_q.push_back(BREAKS[$urandom_range(0, 9)]);
        end
        r = $urandom_range(0, 99);
        if (r >= 65 && r < 72) text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
        if (r < 80) begin
          for (int k = 0; k < ((r >= 72) ? $urandom_range(1, eff) : eff); k++) begin
            ch = word_char(k);
            if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) ch = ch ^ 8'h20;
            text_q.push_back(ch);
          end
          if (r >= 55 && r < 65) text_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
        end else if (r < 90) begin
          for (int k = $urandom_range(1, 6); k > 0; k--) begin
            text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
          end
        end else begin
          for (int k = $urandom_range(1, 4); k > 0; k--) text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 1)) text_q.push_back(BREAKS[$urandom_range(0, 9)]);
      r = ($urandom_range(0, 99) < 85) ? 1 : 0;
      for (int i = 0; i < text_q.size(); i++) begin
        push_text(text_q[i], r != 0 && (i == text_q.size() - 1), 1'b0, 8'h00);
      end
    end
    calm = 1'b0;

    drain_outputs();
    $display("summary: %0d text bytes in %0d finished texts over %0d random word settings",
             text_sent, texts_done, cfg_phases);
    $display("summary: %0d result transactions checked, %0d bytes masked, %0d mismatches",
             results_checked, masked_bytes, mismatches);
    if (mismatches == 0 && censored_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/wwc_pkg.sv
rtl/wwc_cell.sv
rtl/wwc_obuf.sv
rtl/whole_word_censor_filter_core.sv
sim/whole_word_censor_filter_core_tb.sv
